[sv/pr_pkg.sv]
// Shared types and constants for the dense PageRank engine.
// No dependencies; every other file refers to this package by scoped names.
package pr_pkg;

  // Default node capacity and fixed-point one (Q16.16)
  localparam int unsigned MaxNodes = 64;
  localparam int unsigned QOne     = 65536;

  // Quotient width of the shared divider; every quotient is at most one
  localparam int unsigned QuotW    = 17;
  // Dividend width: a Q16.16 entry shifted up by 16
  localparam int unsigned DvdW     = 48;

  // Configuration register reset values
  localparam logic [6:0]  NodeCountRst = 7'd64;
  localparam logic [16:0] DampingRst   = 17'd55706;
  localparam logic [7:0]  IterCountRst = 8'd50;
  localparam logic        IndexBaseRst = 1'b0;

  // Configuration register indexes
  localparam logic [1:0] CfgNodeCount = 2'd0;
  localparam logic [1:0] CfgDamping   = 2'd1;
  localparam logic [1:0] CfgIterCount = 2'd2;
  localparam logic [1:0] CfgIndexBase = 2'd3;

  // Command kinds
  typedef enum logic [1:0] {
    KIND_BEGIN   = 2'd0,
    KIND_EDGE    = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] src_node;
    logic [6:0] dst_node;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  node;
    logic [16:0] rank;
    logic        last;
  } res_t;

endpackage

[sv/pr_div.sv]
// Restoring divider, one quotient bit per cycle, quotient known to be at most one (Q16).
// Depends on pr_pkg for the quotient and dividend widths.
module pr_div #(
  parameter int unsigned DvsW = 38
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pr_pkg::DvdW-1:0]   dividend_i,
  input  logic [DvsW-1:0]           divisor_i,
  output logic                      done_o,
  output logic [pr_pkg::QuotW-1:0]  quot_o
);

  localparam int unsigned Sh   = pr_pkg::QuotW - 1;
  localparam int unsigned CmpW = (DvsW + Sh > pr_pkg::DvdW) ? DvsW + Sh : pr_pkg::DvdW;
  localparam int unsigned CntW = $clog2(pr_pkg::QuotW);

  logic                     run_q;
  logic                     done_q;
  logic [CntW-1:0]          cnt_q;
  logic [CmpW-1:0]          rem_q;
  logic [CmpW-1:0]          dsh_q;
  logic [pr_pkg::QuotW-1:0] quot_q;
  logic                     ge;

  assign ge = rem_q >= dsh_q;

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(Sh)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Shift and subtract datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= CmpW'(dividend_i);
      dsh_q  <= CmpW'(divisor_i) << Sh;
      quot_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[pr_pkg::QuotW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[sv/pagerank_dense_iteration.sv]
// Dense PageRank engine top level: command sequencer, matrix and rank memories.
// Depends on pr_pkg and instantiates pr_div.
//
// A command is taken when start_i is high and busy_o is low; busy_o stays high until the
// command has finished. Begin writes every matrix entry, one per cycle through the single
// matrix write port, after the fill divide. An edge is read, then written back. Compute is
// bound by the one matrix read port and the divider: it divides for 1/n, then for each
// column sums it and normalizes its entries through the divider (one entry per cycle for
// an empty column), then runs iteration_count passes of multiply-accumulate, then output.
// Results appear on res_o one per cycle with res_valid_o high and cannot be held off,
// so the receiver must take them as they come.
module pagerank_dense_iteration #(
  parameter int unsigned MAX_NODES = pr_pkg::MaxNodes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pr_pkg::cmd_t  cmd_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output pr_pkg::res_t  res_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [16:0]   cfg_data_i
);

  localparam int unsigned AW   = $clog2(MAX_NODES);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned MAW  = 2 * AW;
  localparam int unsigned SumW = 32 + AW;
  localparam int unsigned PrdW = 32 + pr_pkg::QuotW;
  localparam int unsigned AccW = PrdW + AW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FDIV_GO = 4'd1;
  localparam logic [3:0] S_FDIV_W  = 4'd2;
  localparam logic [3:0] S_FILL    = 4'd3;
  localparam logic [3:0] S_EDGE_RD = 4'd4;
  localparam logic [3:0] S_EDGE_WR = 4'd5;
  localparam logic [3:0] S_INV_GO  = 4'd6;
  localparam logic [3:0] S_INV_W   = 4'd7;
  localparam logic [3:0] S_NSUM    = 4'd8;
  localparam logic [3:0] S_NRD     = 4'd9;
  localparam logic [3:0] S_NDIV_GO = 4'd10;
  localparam logic [3:0] S_NDIV_W  = 4'd11;
  localparam logic [3:0] S_RINIT   = 4'd12;
  localparam logic [3:0] S_MV      = 4'd13;
  localparam logic [3:0] S_EMIT    = 4'd14;

  // Configuration registers
  logic [6:0]  node_count_q, node_count_d;
  logic [16:0] damping_q, damping_d;
  logic [7:0]  iter_count_q, iter_count_d;
  logic        index_base_q, index_base_d;

  // Control state
  logic [3:0]     state_q, state_d;
  logic [CW-1:0]  row_q, row_d;
  logic [CW-1:0]  col_q, col_d;
  logic [MAW-1:0] fill_addr_q, fill_addr_d;
  logic           rd_vld_q, rd_vld_d;
  logic           prod_vld_q, prod_vld_d;
  logic           bank_q, bank_d;
  logic [7:0]     iter_q, iter_d;

  // Datapath registers
  logic [MAW-1:0]           edge_addr_q, edge_addr_d;
  logic [pr_pkg::QuotW-1:0] fill_val_q, fill_val_d;
  logic [pr_pkg::QuotW-1:0] inv_n_q, inv_n_d;
  logic [SumW-1:0]          sum_q, sum_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic [PrdW-1:0]          prod_q, prod_d;
  logic [AW-1:0]            emit_idx_q, emit_idx_d;

  // Memories
  logic [31:0]              mat_mem [2**MAW];
  logic [31:0]              mrd_q;
  logic                     mat_we;
  logic [MAW-1:0]           mat_waddr, mat_raddr;
  logic [31:0]              mat_wdata;
  logic [pr_pkg::QuotW-1:0] rank_mem [2**(AW+1)];
  logic [pr_pkg::QuotW-1:0] rrd_q;
  logic                     rank_we;
  logic [AW:0]              rank_waddr, rank_raddr;
  logic [pr_pkg::QuotW-1:0] rank_wdata;

  // Divider
  logic                     div_start;
  logic [pr_pkg::DvdW-1:0]  div_dvd;
  logic [SumW-1:0]          div_dvs;
  logic                     div_done;
  logic [pr_pkg::QuotW-1:0] div_quot;

  // Effective configuration
  logic [CW-1:0]  n_w;
  logic [16:0]    damp_w;
  logic           accept;
  logic [6:0]     src_adj, dst_adj;
  logic           edge_ok;
  logic [32:0]    edge_sum;
  logic [AccW-17:0] mv_shift;
  logic [pr_pkg::QuotW-1:0] mv_rank;

  always_comb begin
    if (node_count_q == 7'd0) begin
      n_w = CW'(1);
    end else if (node_count_q > 7'(MAX_NODES)) begin
      n_w = CW'(MAX_NODES);
    end else begin
      n_w = CW'(node_count_q);
    end
  end

  assign damp_w = (damping_q > 17'(pr_pkg::QOne)) ? 17'(pr_pkg::QOne) : damping_q;
  assign busy_o = state_q != S_IDLE;
  assign accept = start_i && !busy_o;

  // Remove index base and range-check the edge
  assign src_adj = cmd_i.src_node - 7'(index_base_q);
  assign dst_adj = cmd_i.dst_node - 7'(index_base_q);
  assign edge_ok = (cmd_i.src_node >= 7'(index_base_q)) &&
                   (cmd_i.dst_node >= 7'(index_base_q)) &&
                   (src_adj < 7'(n_w)) && (dst_adj < 7'(n_w));

  assign edge_sum = {1'b0, mrd_q} + 33'(damp_w);
  assign mv_shift = acc_q[AccW-1:16];
  assign mv_rank  = (mv_shift > (AccW-16)'(pr_pkg::QOne)) ? pr_pkg::QuotW'(pr_pkg::QOne)
                                                          : mv_shift[pr_pkg::QuotW-1:0];

  // Next state, counters and memory controls
  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    fill_addr_d  = fill_addr_q;
    rd_vld_d     = 1'b0;
    prod_vld_d   = 1'b0;
    bank_d       = bank_q;
    iter_d       = iter_q;
    edge_addr_d  = edge_addr_q;
    fill_val_d   = fill_val_q;
    inv_n_d      = inv_n_q;
    sum_d        = sum_q;
    acc_d        = acc_q;
    prod_d       = prod_q;
    emit_idx_d   = emit_idx_q;
    node_count_d = node_count_q;
    damping_d    = damping_q;
    iter_count_d = iter_count_q;
    index_base_d = index_base_q;
    mat_we       = 1'b0;
    mat_waddr    = '0;
    mat_wdata    = '0;
    mat_raddr    = '0;
    rank_we      = 1'b0;
    rank_waddr   = '0;
    rank_wdata   = '0;
    rank_raddr   = '0;
    div_start    = 1'b0;
    div_dvd      = '0;
    div_dvs      = SumW'(n_w);

    // Configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pr_pkg::CfgNodeCount: node_count_d = cfg_data_i[6:0];
        pr_pkg::CfgDamping:   damping_d    = cfg_data_i;
        pr_pkg::CfgIterCount: iter_count_d = cfg_data_i[7:0];
        pr_pkg::CfgIndexBase: index_base_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          row_d = '0;
          col_d = '0;
          case (cmd_i.kind)
            pr_pkg::KIND_BEGIN: state_d = S_FDIV_GO;
            pr_pkg::KIND_EDGE: begin
              edge_addr_d = {dst_adj[AW-1:0], src_adj[AW-1:0]};
              if (edge_ok) begin
                state_d = S_EDGE_RD;
              end
            end
            pr_pkg::KIND_COMPUTE: state_d = S_INV_GO;
            default: ;
          endcase
        end
      end
      S_FDIV_GO: begin
        div_start = 1'b1;
        div_dvd   = pr_pkg::DvdW'(17'(pr_pkg::QOne) - damp_w);
        state_d   = S_FDIV_W;
      end
      S_FDIV_W: begin
        if (div_done) begin
          fill_val_d  = div_quot;
          fill_addr_d = '0;
          state_d     = S_FILL;
        end
      end
      S_FILL: begin
        // Sweep the whole matrix, one entry a cycle
        mat_we      = 1'b1;
        mat_waddr   = fill_addr_q;
        mat_wdata   = 32'(fill_val_q);
        fill_addr_d = fill_addr_q + MAW'(1);
        if (fill_addr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_EDGE_RD: begin
        mat_raddr = edge_addr_q;
        state_d   = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        mat_we    = 1'b1;
        mat_waddr = edge_addr_q;
        mat_wdata = edge_sum[32] ? 32'hFFFF_FFFF : edge_sum[31:0];
        state_d   = S_IDLE;
      end
      S_INV_GO: begin
        div_start = 1'b1;
        div_dvd   = pr_pkg::DvdW'(pr_pkg::QOne);
        state_d   = S_INV_W;
      end
      S_INV_W: begin
        if (div_done) begin
          inv_n_d = div_quot;
          sum_d   = '0;
          state_d = S_NSUM;
        end
      end
      S_NSUM: begin
        // Stream one column through the read port and sum it
        if (row_q < n_w) begin
          mat_raddr = {row_q[AW-1:0], col_q[AW-1:0]};
          rd_vld_d  = 1'b1;
          row_d     = row_q + CW'(1);
        end
        if (rd_vld_q) begin
          sum_d = sum_q + SumW'(mrd_q);
        end
        if (row_q == n_w && !rd_vld_q) begin
          row_d   = '0;
          state_d = S_NRD;
        end
      end
      S_NRD: begin
        if (row_q == n_w) begin
          row_d = '0;
          sum_d = '0;
          col_d = col_q + CW'(1);
          state_d = (col_q + CW'(1) == n_w) ? S_RINIT : S_NSUM;
        end else if (sum_q == '0) begin
          // Empty column: write the uniform value
          mat_we    = 1'b1;
          mat_waddr = {row_q[AW-1:0], col_q[AW-1:0]};
          mat_wdata = 32'(inv_n_q);
          row_d     = row_q + CW'(1);
        end else begin
          mat_raddr = {row_q[AW-1:0], col_q[AW-1:0]};
          state_d   = S_NDIV_GO;
        end
      end
      S_NDIV_GO: begin
        div_start = 1'b1;
        div_dvd   = {mrd_q, 16'b0};
        div_dvs   = sum_q;
        state_d   = S_NDIV_W;
      end
      S_NDIV_W: begin
        div_dvs = sum_q;
        if (div_done) begin
          mat_we    = 1'b1;
          mat_waddr = {row_q[AW-1:0], col_q[AW-1:0]};
          mat_wdata = 32'(div_quot);
          row_d     = row_q + CW'(1);
          state_d   = S_NRD;
        end
      end
      S_RINIT: begin
        if (row_q < n_w) begin
          rank_we    = 1'b1;
          rank_waddr = {1'b0, row_q[AW-1:0]};
          rank_wdata = inv_n_q;
          row_d      = row_q + CW'(1);
        end else begin
          row_d   = '0;
          col_d   = '0;
          bank_d  = 1'b0;
          iter_d  = '0;
          acc_d   = '0;
          state_d = (iter_count_q == 8'd0) ? S_EMIT : S_MV;
        end
      end
      S_MV: begin
        // Issue, multiply, accumulate one row of M times the previous ranks
        if (col_q < n_w) begin
          mat_raddr  = {row_q[AW-1:0], col_q[AW-1:0]};
          rank_raddr = {bank_q, col_q[AW-1:0]};
          rd_vld_d   = 1'b1;
          col_d      = col_q + CW'(1);
        end
        prod_vld_d = rd_vld_q;
        if (rd_vld_q) begin
          prod_d = mrd_q * rrd_q;
        end
        if (prod_vld_q) begin
          acc_d = acc_q + AccW'(prod_q);
        end
        if (col_q == n_w && !rd_vld_q && !prod_vld_q) begin
          rank_we    = 1'b1;
          rank_waddr = {~bank_q, row_q[AW-1:0]};
          rank_wdata = mv_rank;
          acc_d      = '0;
          col_d      = '0;
          if (row_q + CW'(1) == n_w) begin
            row_d  = '0;
            bank_d = ~bank_q;
            iter_d = iter_q + 8'd1;
            if (iter_q + 8'd1 == iter_count_q) begin
              state_d = S_EMIT;
            end
          end else begin
            row_d = row_q + CW'(1);
          end
        end
      end
      S_EMIT: begin
        if (row_q < n_w) begin
          rank_raddr = {bank_q, row_q[AW-1:0]};
          rd_vld_d   = 1'b1;
          emit_idx_d = row_q[AW-1:0];
          row_d      = row_q + CW'(1);
        end
        if (row_q == n_w && !rd_vld_q) begin
          row_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      row_q        <= '0;
      col_q        <= '0;
      fill_addr_q  <= '0;
      rd_vld_q     <= 1'b0;
      prod_vld_q   <= 1'b0;
      bank_q       <= 1'b0;
      iter_q       <= '0;
      node_count_q <= pr_pkg::NodeCountRst;
      damping_q    <= pr_pkg::DampingRst;
      iter_count_q <= pr_pkg::IterCountRst;
      index_base_q <= pr_pkg::IndexBaseRst;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      fill_addr_q  <= fill_addr_d;
      rd_vld_q     <= rd_vld_d;
      prod_vld_q   <= prod_vld_d;
      bank_q       <= bank_d;
      iter_q       <= iter_d;
      node_count_q <= node_count_d;
      damping_q    <= damping_d;
      iter_count_q <= iter_count_d;
      index_base_q <= index_base_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    edge_addr_q <= edge_addr_d;
    fill_val_q  <= fill_val_d;
    inv_n_q     <= inv_n_d;
    sum_q       <= sum_d;
    acc_q       <= acc_d;
    prod_q      <= prod_d;
    emit_idx_q  <= emit_idx_d;
  end

  // Matrix memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    mrd_q <= mat_mem[mat_raddr];
  end

  // Rank memory, two banks for current and previous ranks
  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rrd_q <= rank_mem[rank_raddr];
  end

  pr_div #(
    .DvsW (SumW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Result transfer
  assign res_valid_o = rd_vld_q && (state_q == S_EMIT);
  assign res_o.node  = 6'(emit_idx_q);
  assign res_o.rank  = rrd_q;
  assign res_o.last  = emit_idx_q == AW'(n_w - CW'(1));

  // Results only come out while a command is in progress
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o)
    else $error("result transfer while idle");

  // Matrix is never written while idle
  a_mat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mat_we |-> (state_q != S_IDLE))
    else $error("matrix write while idle");

  // A divide only finishes while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_FDIV_W || state_q == S_INV_W || state_q == S_NDIV_W))
    else $error("divider done outside a wait state");

endmodule

[sim/pagerank_dense_iteration_test.sv]
// Self-checking testbench for the dense PageRank engine: commands in, ranks out.
// Depends on pr_pkg and pagerank_dense_iteration; predicts ranks with its own model.
module pagerank_dense_iteration_test;

  localparam int unsigned CycleLimit  = 10000000;
  localparam int unsigned RandomItems = 380;
  localparam logic [1:0]  KindUnused  = 2'd3;

  // Rank predictor and store of expected per-node ranks
  class rank_scoreboard;
    localparam int unsigned MaxEntries = 4096;

    logic [6:0]  node_count;
    logic [16:0] damping;
    logic [7:0]  iter_count;
    logic        index_base;
    logic [31:0] link_m[MaxEntries];
    logic [31:0] rank_v[64];
    logic [31:0] prev_v[64];
    pr_pkg::res_t rank_q[$];
    int unsigned  fails;

    function new();
      node_count = pr_pkg::NodeCountRst;
      damping    = pr_pkg::DampingRst;
      iter_count = pr_pkg::IterCountRst;
      index_base = pr_pkg::IndexBaseRst;
      fails      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] data);
      case (idx)
        pr_pkg::CfgNodeCount: node_count = data[6:0];
        pr_pkg::CfgDamping:   damping    = data;
        pr_pkg::CfgIterCount: iter_count = data[7:0];
        pr_pkg::CfgIndexBase: index_base = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned nodes_used();
      if (node_count == 0) return 1;
      if (node_count > 64) return 64;
      return node_count;
    endfunction

    function logic [31:0] damping_used();
      return (damping > pr_pkg::QOne) ? pr_pkg::QOne : damping;
    endfunction

    // Note an accepted command and queue the ranks it produces
    function void note_cmd(pr_pkg::cmd_t c);
      int unsigned n;
      int unsigned src;
      int unsigned dst;
      logic [63:0] sum;
      logic [63:0] acc;
      logic [63:0] wide;
      pr_pkg::res_t r;
      n = nodes_used();
      case (c.kind)
        pr_pkg::KIND_BEGIN: begin
          for (int k = 0; k < MaxEntries; k++) link_m[k] = (pr_pkg::QOne - damping_used()) / n;
        end
        pr_pkg::KIND_EDGE: begin
          src = c.src_node;
          dst = c.dst_node;
          if (src >= index_base && dst >= index_base) begin
            src -= index_base;
            dst -= index_base;
            if (src < n && dst < n) begin
              wide = 64'(link_m[dst*64+src]) + damping_used();
              link_m[dst*64+src] = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
            end
          end
        end
        pr_pkg::KIND_COMPUTE: begin
          // Normalize columns in place; an empty column becomes uniform
          for (int j = 0; j < n; j++) begin
            sum = 0;
            for (int i = 0; i < n; i++) sum += link_m[i*64+j];
            for (int i = 0; i < n; i++) begin
              if (sum != 0) begin
                wide = 64'(link_m[i*64+j]) << 16;
                wide = wide / sum;
                link_m[i*64+j] = wide[31:0];
              end else begin
                link_m[i*64+j] = pr_pkg::QOne / n;
              end
            end
          end
          for (int i = 0; i < n; i++) rank_v[i] = pr_pkg::QOne / n;
          // Power iteration with saturation at one
          for (int it = 0; it < iter_count; it++) begin
            for (int i = 0; i < n; i++) prev_v[i] = rank_v[i];
            for (int i = 0; i < n; i++) begin
              acc = 0;
              for (int j = 0; j < n; j++) acc += 64'(prev_v[j]) * 64'(link_m[i*64+j]);
              acc = acc >> 16;
              rank_v[i] = (acc > pr_pkg::QOne) ? pr_pkg::QOne : acc[31:0];
            end
          end
          for (int i = 0; i < n; i++) begin
            r.node = i[5:0];
            r.rank = rank_v[i][16:0];
            r.last = (i == n - 1);
            rank_q.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one rank transfer with the oldest expectation
    function void check_rank(pr_pkg::res_t got);
      pr_pkg::res_t want;
      if (rank_q.size() == 0) begin
        $display("%0t: unexpected result node %0d rank %0d last %0d",
                 $time, got.node, got.rank, got.last);
        fails++;
        return;
      end
      want = rank_q.pop_front();
      if (got.node !== want.node || got.rank !== want.rank || got.last !== want.last) begin
        $display("%0t: mismatch expected node %0d rank %0d last %0d,",
                 $time, want.node, want.rank, want.last,
                 " got node %0d rank %0d last %0d", got.node, got.rank, got.last);
        fails++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         start_i;
  pr_pkg::cmd_t cmd_i;
  logic         busy_o;
  logic         res_valid_o;
  pr_pkg::res_t res_o;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [16:0]  cfg_data_i;

  rank_scoreboard ranks;
  int unsigned    cycles = 0;
  int unsigned    gap_max;
  int unsigned    nodes_now;
  int unsigned    items_sent;

  pagerank_dense_iteration dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Check every rank transfer
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) ranks.check_rank(res_o);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Transfer one command, then hold off for a random gap
  task automatic send(logic [1:0] kind, int unsigned src, int unsigned dst);
    pr_pkg::cmd_t c;
    int unsigned  g;
    c.kind     = pr_pkg::kind_e'(kind);
    c.src_node = src[6:0];
    c.dst_node = dst[6:0];
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o);
    ranks.note_cmd(c);
    items_sent++;
    g = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until the engine is idle and every rank has arrived
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (busy_o || ranks.rank_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [16:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    ranks.write_reg(idx, data);
    nodes_now = ranks.nodes_used();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(logic [6:0] n, logic [16:0] damp, logic [7:0] iters, logic base);
    drain();
    write_cfg(pr_pkg::CfgNodeCount, 17'(n));
    write_cfg(pr_pkg::CfgDamping, damp);
    write_cfg(pr_pkg::CfgIterCount, 17'(iters));
    write_cfg(pr_pkg::CfgIndexBase, 17'(base));
  endtask

  // Mostly in-range edges, some with arbitrary node numbers
  task automatic random_edge();
    int unsigned b;
    b = ranks.index_base;
    if ($urandom_range(0, 6) == 0)
      send(pr_pkg::KIND_EDGE, $urandom_range(0, 127), $urandom_range(0, 127));
    else
      send(pr_pkg::KIND_EDGE, b + $urandom_range(0, nodes_now - 1),
           b + $urandom_range(0, nodes_now - 1));
  endtask

  initial begin
    int unsigned edges;
    int unsigned pick;
    ranks      = new();
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    cmd_i      = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    gap_max    = 0;
    items_sent = 0;
    nodes_now  = ranks.nodes_used();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small graph, out-of-range edges, unused kind, repeated compute
    setup(7'd4, 17'd55706, 8'd3, 1'b0);
    send(pr_pkg::KIND_BEGIN, 0, 0);
    send(pr_pkg::KIND_EDGE, 0, 1);
    send(pr_pkg::KIND_EDGE, 1, 2);
    send(pr_pkg::KIND_EDGE, 2, 0);
    send(pr_pkg::KIND_EDGE, 3, 3);
    send(pr_pkg::KIND_EDGE, 0, 0);
    send(pr_pkg::KIND_EDGE, 4, 0);
    send(pr_pkg::KIND_EDGE, 127, 127);
    send(KindUnused, 127, 127);
    send(pr_pkg::KIND_COMPUTE, 0, 0);
    send(pr_pkg::KIND_COMPUTE, 0, 0);

    // One-based numbering, full damping so empty columns go uniform, zero iterations
    setup(7'd5, 17'd65536, 8'd0, 1'b1);
    send(pr_pkg::KIND_BEGIN, 0, 0);
    send(pr_pkg::KIND_EDGE, 1, 1);
    send(pr_pkg::KIND_EDGE, 0, 3);
    send(pr_pkg::KIND_EDGE, 5, 5);
    send(pr_pkg::KIND_EDGE, 6, 1);
    send(pr_pkg::KIND_COMPUTE, 0, 0);

    // No damping, two nodes, most iterations
    setup(7'd2, 17'd0, 8'd255, 1'b0);
    send(pr_pkg::KIND_BEGIN, 0, 0);
    send(pr_pkg::KIND_EDGE, 0, 1);
    send(pr_pkg::KIND_COMPUTE, 0, 0);

    // Zero node count and damping above one
    setup(7'd0, 17'h1FFFF, 8'd1, 1'b0);
    send(pr_pkg::KIND_BEGIN, 0, 0);
    send(pr_pkg::KIND_EDGE, 0, 0);
    send(pr_pkg::KIND_COMPUTE, 0, 0);

    // Node count above capacity: full-size graph, one iteration
    setup(7'd127, 17'd55706, 8'd1, 1'b0);
    send(pr_pkg::KIND_BEGIN, 0, 0);
    send(pr_pkg::KIND_EDGE, 63, 0);
    send(pr_pkg::KIND_EDGE, 0, 63);
    send(pr_pkg::KIND_COMPUTE, 0, 0);

    // Shrink the node count after the fill
    setup(7'd64, 17'd40000, 8'd4, 1'b0);
    send(pr_pkg::KIND_BEGIN, 0, 0);
    drain();
    write_cfg(pr_pkg::CfgNodeCount, 17'd6);
    send(pr_pkg::KIND_EDGE, 5, 0);
    send(pr_pkg::KIND_EDGE, 2, 3);
    send(pr_pkg::KIND_COMPUTE, 0, 0);

    // Random graphs: fill, many edges, a few computes, with varied pacing
    items_sent = 0;
    while (items_sent < RandomItems) begin
      pick = $urandom_range(0, 3);
      gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 14;
      setup(($urandom_range(0, 5) == 0) ? 7'($urandom_range(11, 20)) : 7'($urandom_range(1, 10)),
            ($urandom_range(0, 4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536)),
            8'($urandom_range(0, 20)), 1'($urandom));
      send(pr_pkg::KIND_BEGIN, 0, 0);
      edges = $urandom_range(20, 40);
      for (int e = 0; e < edges; e++) begin
        pick = $urandom_range(0, 39);
        if (pick == 0) send(KindUnused, $urandom_range(0, 127), $urandom_range(0, 127));
        else if (pick == 1) send(pr_pkg::KIND_COMPUTE, 0, 0);
        else if (pick == 2) send(pr_pkg::KIND_BEGIN, 0, 0);
        else random_edge();
      end
      send(pr_pkg::KIND_COMPUTE, 0, 0);
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (ranks.fails == 0 && ranks.rank_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
